FILE: design/rgb_3x3_convolution_filter_defines.svh
// Assertion macros used by the checker file.
`ifndef RGB_3X3_CONVOLUTION_FILTER_DEFINES_SVH
`define RGB_3X3_CONVOLUTION_FILTER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RCF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rcf assertion failed");

// Check a property on every clock edge, reset included.
`define RCF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rcf assertion failed");

`endif

FILE: design/rcf_pkg.sv
// Shared types and constants of the RGB 3x3 convolution filter.
`timescale 1ns / 1ps
package rcf_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int QDEPTH         = 2;
  localparam logic [7:0] CLAMP_MAX = 8'd255;

  typedef logic [23:0] pixel_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_COEF_TOP,
    REG_COEF_MID,
    REG_COEF_BOT,
    REG_SCALE,
    REG_WIDTH,
    REG_HEIGHT,
    REG_SEL_COLS,
    REG_SEL_ROWS
  } cfg_reg_t;

  // One classified pixel handed from front to back.
  typedef struct packed {
    pixel_t [8:0] win;
    logic         filt;
    logic         last;
  } job_t;

  // Kernel settings seen by the back end.
  typedef struct packed {
    logic [2:0][23:0] coef;
    logic [19:0]      scale;
  } kern_cfg_t;

endpackage

FILE: design/rgb_3x3_convolution_filter.sv
// Top level of the RGB 3x3 convolution filter.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_push / in_full    | in_command, in_red, in_green, in_blue
//  out_    | output    | out_empty / out_pop  | out_red, out_green, out_blue, out_frame_last
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// The front end takes no new item while it writes one back: the line store read is
// registered and written back in the following cycle.
// The back end steps a filtered pixel through three kernel rows, one scale multiply
// and one output load, and a passed-through pixel straight to the output load.
// A 2-entry queue between them lets the input run ahead while a result stalls.
// Reset is synchronous; line stores need no clearing pass. cfg_ready is always high.
`timescale 1ns / 1ps
module rgb_3x3_convolution_filter
  import rcf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_command,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_frame_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [2:0][23:0] coef_r;
  logic [19:0]      scale_r;
  logic [12:0]      width_r, height_r;
  logic [23:0]      sel_cols_r, sel_rows_r;
  kern_cfg_t        kcfg;
  logic             q_push, q_full, q_pop, q_empty;
  job_t             q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // Decode register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r     <= {24'd0, 24'h010000, 24'd0};
      scale_r    <= 20'd65536;
      width_r    <= 13'd1;
      height_r   <= 13'd1;
      sel_cols_r <= '0;
      sel_rows_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COEF_TOP: coef_r[0]  <= cfg_data;
        REG_COEF_MID: coef_r[1]  <= cfg_data;
        REG_COEF_BOT: coef_r[2]  <= cfg_data;
        REG_SCALE:    scale_r    <= cfg_data[19:0];
        REG_WIDTH:    width_r    <= cfg_data[12:0];
        REG_HEIGHT:   height_r   <= cfg_data[12:0];
        REG_SEL_COLS: sel_cols_r <= cfg_data;
        REG_SEL_ROWS: sel_rows_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign kcfg.coef  = coef_r;
  assign kcfg.scale = scale_r;

  rcf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_command(in_command),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .width_cfg (width_r),
    .height_cfg(height_r),
    .sel_cols  (sel_cols_r),
    .sel_rows  (sel_rows_r),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  rcf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .empty    (q_empty)
  );

  rcf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_data        (q_rdata),
    .kcfg          (kcfg),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_last(out_frame_last)
  );

endmodule

FILE: design/rcf_queue.sv
// Short job queue between front and back ends.
`timescale 1ns / 1ps
module rcf_queue
  import rcf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);

  localparam int PTRW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNTW = $clog2(QDEPTH + 1);

  job_t            ent_r [QDEPTH];
  logic [PTRW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;

  assign full     = (cnt_r == CNTW'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = ent_r[rd_ptr_r];

  // Store entries.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (32'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + PTRW'(1);
      end
      if (pop && !empty) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + PTRW'(1);
      end
      if ((push && !full) && !(pop && !empty)) begin
        cnt_r <= cnt_r + CNTW'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

endmodule

FILE: design/rcf_front.sv
// Front end: line stores, window, position tracking and pixel classification.
`timescale 1ns / 1ps
module rcf_front
  import rcf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_command,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [12:0] width_cfg,
  input  logic [12:0] height_cfg,
  input  logic [23:0] sel_cols,
  input  logic [23:0] sel_rows,
  output logic        q_push,
  output job_t        q_data,
  input  logic        q_full
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = $clog2(MAX_WIDTH + 2);

  typedef enum logic {F_IDLE, F_WORK} fstate_t;

  fstate_t       state_r;
  logic          cmd_r;
  pixel_t        pix_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [PW-1:0] pend_r;
  pixel_t [8:0]  win_r;
  pixel_t [8:0]  win_nxt;
  pixel_t        up_rd_r, mid_rd_r;
  pixel_t        upper_mem  [MAX_WIDTH];
  pixel_t        middle_mem [MAX_WIDTH];

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          accept, drop, emit;
  logic [CW-1:0] ocol;
  logic [RW-1:0] orow;
  logic          filt, last;

  // Clamp frame size to the supported range.
  always_comb begin
    if (width_cfg == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_cfg) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_cfg);
    end
    if (height_cfg == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_cfg) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_cfg);
    end
  end

  assign in_full = (state_r == F_WORK) || q_full;
  assign accept  = in_push && !in_full;
  // A drain with nothing pending is taken and has no effect.
  assign drop    = in_command && (pend_r == '0);
  assign emit    = cmd_r || (32'(pend_r) >= 32'(w_eff) + 1);

  // Shift the window one column left and load the new right column.
  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = up_rd_r;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid_rd_r;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = pix_r;
  end

  // Locate the window centre: one row and one column behind the input.
  always_comb begin
    logic signed [RW+1:0] t;
    logic signed [RW+1:0] hs;
    hs = signed'((RW + 2)'(h_eff));
    if (col_r != '0) begin
      ocol = col_r - CW'(1);
      t    = signed'({2'b00, row_r}) - (RW + 2)'(1);
    end else begin
      ocol = CW'(w_eff - WW'(1));
      t    = signed'({2'b00, row_r}) - (RW + 2)'(2);
    end
    if (t < 0) begin
      t = t + hs;
    end
    if (t < 0) begin
      t = t + hs;
    end
    orow = RW'(t);
  end

  // Classify the centre: interior and inside the selection gets filtered.
  always_comb begin
    filt = (orow >= RW'(1)) && (32'(orow) + 2 <= 32'(h_eff)) &&
           (ocol >= CW'(1)) && (32'(ocol) + 2 <= 32'(w_eff)) &&
           (32'(ocol) >= 32'(sel_cols[11:0])) && (32'(ocol) <= 32'(sel_cols[23:12])) &&
           (32'(orow) >= 32'(sel_rows[11:0])) && (32'(orow) <= 32'(sel_rows[23:12]));
    last = (32'(orow) + 1 == 32'(h_eff)) && (32'(ocol) + 1 == 32'(w_eff));
  end

  assign q_push      = (state_r == F_WORK) && emit;
  assign q_data.win  = win_nxt;
  assign q_data.filt = filt;
  assign q_data.last = last;

  // Line stores: read on accept, write back in the following cycle.
  always_ff @(posedge clk) begin
    if (accept && !drop) begin
      up_rd_r  <= upper_mem[col_r];
      mid_rd_r <= middle_mem[col_r];
    end
    if (state_r == F_WORK) begin
      upper_mem[col_r]  <= mid_rd_r;
      middle_mem[col_r] <= pix_r;
    end
  end

  // Sequence each item, hold position, window and pending count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      pend_r  <= '0;
      win_r   <= '0;
      cmd_r   <= 1'b0;
      pix_r   <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept && !drop) begin
            cmd_r   <= in_command;
            pix_r   <= in_command ? '0 : {in_blue, in_green, in_red};
            state_r <= F_WORK;
          end
        end
        F_WORK: begin
          win_r   <= win_nxt;
          state_r <= F_IDLE;
          if (cmd_r) begin
            pend_r <= pend_r - PW'(1);
          end else if (!emit) begin
            pend_r <= pend_r + PW'(1);
          end
          if (cmd_r && pend_r == PW'(1)) begin
            col_r <= '0;
            row_r <= '0;
          end else if (32'(col_r) + 1 >= 32'(w_eff)) begin
            col_r <= '0;
            row_r <= (32'(row_r) + 1 >= 32'(h_eff)) ? '0 : row_r + RW'(1);
          end else begin
            col_r <= col_r + CW'(1);
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: design/rcf_back.sv
// Back end: kernel multiply-accumulate, scaling, rounding and output register.
`timescale 1ns / 1ps
module rcf_back
  import rcf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  output logic      q_pop,
  input  job_t      q_data,
  input  kern_cfg_t kcfg,
  output logic      out_empty,
  input  logic      out_pop,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic      out_frame_last
);

  typedef enum logic [1:0] {B_IDLE, B_MAC, B_SCALE, B_DONE} bstate_t;

  bstate_t                  state_r;
  job_t                     job_r;
  logic [1:0]               krow_r;
  logic signed [19:0]       acc_r  [3];
  logic signed [19:0]       acc_nxt[3];
  logic [38:0]              prod_r [3];
  logic [2:0]               pos_r;
  logic [7:0]               res    [3];
  logic                     out_valid_r;
  logic [7:0]               out_red_r, out_green_r, out_blue_r;
  logic                     out_last_r;
  logic                     slot_free;

  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign slot_free = !out_valid_r || out_pop;

  // Add one kernel row of products per channel.
  always_comb begin
    logic signed [7:0]  k;
    logic signed [16:0] p;
    logic [7:0]         px;
    for (int ch = 0; ch < 3; ch++) begin
      acc_nxt[ch] = acc_r[ch];
      for (int c = 0; c < 3; c++) begin
        k  = signed'(kcfg.coef[krow_r][8*c +: 8]);
        px = job_r.win[krow_r * 3 + c][8*ch +: 8];
        p  = k * signed'({1'b0, px});
        acc_nxt[ch] = acc_nxt[ch] + 20'(p);
      end
    end
  end

  // Round half up on the positive magnitude and clamp to a byte; unfiltered pixels pass the centre through.
  always_comb begin
    logic [39:0] rnd;
    for (int ch = 0; ch < 3; ch++) begin
      rnd = {1'b0, prod_r[ch]} + 40'd32768;
      if (!job_r.filt) begin
        res[ch] = job_r.win[4][8*ch +: 8];
      end else if (!pos_r[ch]) begin
        res[ch] = '0;
      end else if (rnd[39:16] > 24'(CLAMP_MAX)) begin
        res[ch] = CLAMP_MAX;
      end else begin
        res[ch] = rnd[23:16];
      end
    end
  end

  // Step through accumulate, scale and output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      krow_r      <= '0;
    end else begin
      // Free the output slot unless a new result loads it in this cycle.
      if (out_pop && out_valid_r && !(state_r == B_DONE && slot_free)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            job_r   <= q_data;
            krow_r  <= '0;
            for (int ch = 0; ch < 3; ch++) begin
              acc_r[ch] <= '0;
            end
            state_r <= q_data.filt ? B_MAC : B_DONE;
          end
        end
        B_MAC: begin
          for (int ch = 0; ch < 3; ch++) begin
            acc_r[ch] <= acc_nxt[ch];
          end
          krow_r <= krow_r + 2'd1;
          if (krow_r == 2'd2) begin
            state_r <= B_SCALE;
          end
        end
        B_SCALE: begin
          for (int ch = 0; ch < 3; ch++) begin
            prod_r[ch] <= acc_r[ch][18:0] * kcfg.scale;
            pos_r[ch]  <= (acc_r[ch] > 0);
          end
          state_r <= B_DONE;
        end
        B_DONE: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_red_r   <= res[0];
            out_green_r <= res[1];
            out_blue_r  <= res[2];
            out_last_r  <= job_r.last;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;
  assign out_frame_last = out_last_r;

endmodule

FILE: design/rcf_checker.sv
// Port-level checks for the RGB 3x3 convolution filter, bound to the top level.
`timescale 1ns / 1ps
`include "rgb_3x3_convolution_filter_defines.svh"
module rcf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_red,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  // Reset leaves no result waiting.
  `RCF_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> out_empty)

  // A waiting result that is not taken stays.
  `RCF_ASSERT(a_hold, !out_empty && !out_pop |=> !out_empty && $stable(out_red))

  // Register writes are never stalled.
  `RCF_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready)

  // The input is open and no result waits right after reset ends.
  `RCF_ASSERT(a_reset_open, $rose(rst_n) |-> !in_full && out_empty)

endmodule

bind rgb_3x3_convolution_filter rcf_checker u_rcf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_full  (in_full),
  .out_empty(out_empty),
  .out_pop  (out_pop),
  .out_red  (out_red),
  .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready)
);

FILE: dv/testbench.sv
// Self-checking testbench for the RGB 3x3 convolution filter.
`timescale 1ns / 1ps
module testbench;
  import rcf_pkg::*;

  localparam bit CMD_PIXEL = 1'b0;
  localparam bit CMD_DRAIN = 1'b1;
  localparam int LINE_DEPTH = 4096;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } rgb_out_t;

  // Predict filter output and compare it against the pixels that come out.
  class filter_scoreboard;
    logic [23:0] coef[3];
    logic [19:0] scale;
    logic [12:0] width_reg, height_reg;
    logic [23:0] sel_cols, sel_rows;
    logic [23:0] upper_line[LINE_DEPTH];
    logic [23:0] middle_line[LINE_DEPTH];
    logic [23:0] win[9];
    int col, row, pending;
    rgb_out_t expected_px[$];
    int errors, checked, filtered;

    function new();
      coef[0] = 0; coef[1] = 24'h010000; coef[2] = 0;
      scale = 20'h10000; width_reg = 1; height_reg = 1;
      sel_cols = 0; sel_rows = 0;
      foreach (upper_line[i]) begin
        upper_line[i] = 0;
        middle_line[i] = 0;
      end
      foreach (win[i]) win[i] = 0;
      col = 0; row = 0; pending = 0;
      errors = 0; checked = 0; filtered = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [23:0] data);
      case (idx)
        REG_COEF_TOP: coef[0] = data;
        REG_COEF_MID: coef[1] = data;
        REG_COEF_BOT: coef[2] = data;
        REG_SCALE:    scale = data[19:0];
        REG_WIDTH:    width_reg = data[12:0];
        REG_HEIGHT:   height_reg = data[12:0];
        REG_SEL_COLS: sel_cols = data;
        REG_SEL_ROWS: sel_rows = data;
        default: ;
      endcase
    endfunction

    function int clip_size(logic [12:0] v);
      if (v == 0) return 1;
      return (v > LINE_DEPTH) ? LINE_DEPTH : int'(v);
    endfunction

    function logic [7:0] conv_channel(int sh);
      int s;
      byte cb;
      int px;
      longint m;
      s = 0;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) begin
          cb = coef[r][8*c +: 8];
          px = int'(win[r*3+c][sh +: 8]);
          s += cb * px;
        end
      if (s <= 0) return 8'd0;
      m = (longint'(s) * longint'(scale) + 32768) >>> 16;
      return (m > 255) ? 8'd255 : m[7:0];
    endfunction

    function void shift_window(logic [23:0] pix);
      int idx;
      idx = col % LINE_DEPTH;
      for (int r = 0; r < 3; r++) begin
        win[r*3] = win[r*3+1];
        win[r*3+1] = win[r*3+2];
      end
      win[2] = upper_line[idx];
      win[5] = middle_line[idx];
      win[8] = pix;
      upper_line[idx] = middle_line[idx];
      middle_line[idx] = pix;
    endfunction

    function void emit_centre(int w, int h);
      longint hw, d;
      int er, ec, c0, c1, r0, r1;
      rgb_out_t px;
      bit filt;
      hw = longint'(w) * h;
      d = (longint'(row) * w + col + 2 * hw - (w + 1)) % hw;
      er = int'(d / w);
      ec = int'(d % w);
      c0 = int'(sel_cols[11:0]); c1 = int'(sel_cols[23:12]);
      r0 = int'(sel_rows[11:0]); r1 = int'(sel_rows[23:12]);
      filt = er >= 1 && er + 2 <= h && ec >= 1 && ec + 2 <= w &&
             ec >= c0 && ec <= c1 && er >= r0 && er <= r1;
      if (filt) begin
        px.red = conv_channel(0);
        px.green = conv_channel(8);
        px.blue = conv_channel(16);
        filtered++;
      end else begin
        px.red = win[4][7:0];
        px.green = win[4][15:8];
        px.blue = win[4][23:16];
      end
      px.last = (d == hw - 1);
      expected_px.push_back(px);
    endfunction

    function void advance(int w, int h);
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col++;
      end
    endfunction

    // Note an accepted input and queue the pixel it causes, if any.
    function void note_input(bit cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int w, h;
      w = clip_size(width_reg);
      h = clip_size(height_reg);
      if (cmd == CMD_DRAIN) begin
        if (pending == 0) return;
        shift_window(24'd0);
        emit_centre(w, h);
        pending--;
        advance(w, h);
        if (pending == 0) begin
          col = 0;
          row = 0;
        end
        return;
      end
      shift_window({b, g, r});
      if (pending >= w + 1) emit_centre(w, h);
      else pending++;
      advance(w, h);
    endfunction

    function void check_result(rgb_out_t got);
      rgb_out_t exp_px;
      if (expected_px.size() == 0) begin
        $error("unexpected pixel r=%0d g=%0d b=%0d last=%0d",
               got.red, got.green, got.blue, got.last);
        errors++;
        return;
      end
      exp_px = expected_px.pop_front();
      checked++;
      if (got.red !== exp_px.red) begin
        $error("out_red expected %0d actual %0d", exp_px.red, got.red);
        errors++;
      end
      if (got.green !== exp_px.green) begin
        $error("out_green expected %0d actual %0d", exp_px.green, got.green);
        errors++;
      end
      if (got.blue !== exp_px.blue) begin
        $error("out_blue expected %0d actual %0d", exp_px.blue, got.blue);
        errors++;
      end
      if (got.last !== exp_px.last) begin
        $error("out_frame_last expected %0d actual %0d", exp_px.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_command = 1'b0;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_red, out_green, out_blue;
  logic        out_frame_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  filter_scoreboard sb = new();
  bit hold_rx = 1'b0;
  bit no_gaps = 1'b0;
  int stall_cycles = 0;
  int items_sent = 0;

  rgb_3x3_convolution_filter dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Observe transfers at the rising edge and run the stall watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full || out_pop && !out_empty || cfg_valid && cfg_ready)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (in_push && !in_full) sb.note_input(in_command, in_red, in_green, in_blue);
      if (out_pop && !out_empty)
        sb.check_result('{out_red, out_green, out_blue, out_frame_last});
      if (stall_cycles >= STALL_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  function int draw_gap();
    if (no_gaps || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 5);
  endfunction

  // Pop results with random gaps; take a long hold-off when asked.
  initial begin
    int gap;
    forever begin
      if (hold_rx) begin
        @(negedge clk);
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rx = 1'b0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        @(negedge clk);
        out_pop <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
    end
  end

  function logic [7:0] rand_level();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one item and hold it until the transfer.
  task automatic push_item(bit cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_command <= cmd;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
    #1;
  endtask

  task automatic push_pixel();
    push_item(CMD_PIXEL, rand_level(), rand_level(), rand_level());
  endtask

  task automatic push_drains();
    while (sb.pending > 0)
      push_item(CMD_DRAIN, rand_level(), rand_level(), rand_level());
  endtask

  // Stop offering and wait until every predicted pixel has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_push <= 1'b0;
    while (sb.expected_px.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [23:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_frame(logic [23:0] c0, logic [23:0] c1, logic [23:0] c2,
                           logic [19:0] scl, logic [12:0] w, logic [12:0] h,
                           logic [23:0] scol, logic [23:0] srow);
    write_cfg(REG_COEF_TOP, c0);
    write_cfg(REG_COEF_MID, c1);
    write_cfg(REG_COEF_BOT, c2);
    write_cfg(REG_SCALE, {4'd0, scl});
    write_cfg(REG_WIDTH, {11'd0, w});
    write_cfg(REG_HEIGHT, {11'd0, h});
    write_cfg(REG_SEL_COLS, scol);
    write_cfg(REG_SEL_ROWS, srow);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random kernel, scale, frame size and selection, then pixels and a flush.
  task automatic random_phase(int n_pix);
    int w, h;
    logic [19:0] scl;
    logic [12:0] wreg, hreg;
    w = $urandom_range(1, 8);
    h = $urandom_range(1, 6);
    wreg = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'(w);
    hreg = ($urandom_range(0, 9) == 0) ? 13'd8191 : 13'(h);
    case ($urandom_range(0, 4))
      0: scl = 20'hFFFFF;
      1: scl = 20'd0;
      2: scl = 20'h10000;
      default: scl = 20'($urandom_range(0, 20'h3000));
    endcase
    set_frame(24'($urandom), 24'($urandom), 24'($urandom), scl, wreg, hreg,
              {12'($urandom_range(0, w)), 12'($urandom_range(0, w))},
              {12'($urandom_range(0, h)), 12'($urandom_range(0, h))});
    for (int i = 0; i < n_pix; i++) begin
      if ($urandom_range(0, 19) == 0)
        push_item(CMD_DRAIN, rand_level(), rand_level(), rand_level());
      else
        push_pixel();
    end
    push_drains();
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain with nothing pending, then a tiny frame at reset settings.
    push_item(CMD_DRAIN, 8'd255, 8'd255, 8'd255);
    push_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0);
    push_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
    push_item(CMD_PIXEL, 8'd1, 8'd128, 8'd254);
    push_drains();
    wait_drained();

    // 3x3 frame, extreme coefficients, whole selection: centre is filtered.
    set_frame(24'h808080, 24'h7F7F7F, 24'h80FF01, 20'hFFFFF, 13'd3, 13'd3,
              24'hFFF000, 24'hFFF000);
    for (int i = 0; i < 9; i++)
      push_item(CMD_PIXEL, (i % 2) ? 8'd255 : 8'd0, 8'(i * 30), 8'd255 - 8'(i));
    push_drains();
    wait_drained();

    // Random frames; one with no gaps, one with a long output hold-off.
    for (int p = 0; p < 20; p++) begin
      no_gaps = (p == 5);
      if (p == 10) hold_rx = 1'b1;
      random_phase((p == 10) ? 22 : $urandom_range(4, 22));
      if (p == 12) begin
        set_frame(24'h010101, 24'h010101, 24'h010101, 20'd7282, 13'd4, 13'd4,
                  24'hFFF000, 24'hFFF000);
        repeat (9) push_pixel();
        wait_drained();
        repeat (9) push_pixel();
        push_drains();
        wait_drained();
      end
    end
    no_gaps = 1'b0;

    repeat (50) @(posedge clk);
    $display("Sent %0d items, checked %0d pixels, %0d of them filtered.",
             items_sent, sb.checked, sb.filtered);
    $display("Covered fill, drains, border and selection, scale and clamp extremes.");
    if (sb.errors == 0 && sb.expected_px.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
